FILE: hdl/dlmb_pkg.sv
// Package for the dense layer MAC/bias block: item kinds, register indexes,
// field widths and the token that travels down the cell chain. No dependencies.
package dlmb_pkg;

    localparam int VALUE_W   = 16;
    localparam int NODE_W    = 4;
    localparam int ROW_W     = 6;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 7;
    localparam int NCOUNT_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam int NODE_CAP  = 16;

    localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIAS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd1;

    // one request as seen by every cell
    typedef struct packed {
        logic                      wr_w;   // weight load for this row/node
        logic                      wr_b;   // bias load for node
        logic                      feat;   // feature value
        logic                      last;   // feature closes the row
        logic [NODE_W-1:0]         node;
        logic [POS_W-1:0]          addr;   // weight row or feature position
        logic [NCOUNT_W-1:0]       nn;     // nodes in use for this feature
        logic [VALUE_W-1:0]        value;
    } tok_t;

endpackage

FILE: hdl/dlmb_if.sv
// Valid/ready channel interfaces for the dense layer MAC/bias block.
// Depends on dlmb_pkg.
interface dlmb_item_if import dlmb_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [ROW_W-1:0]           weight_row;
    logic [NODE_W-1:0]          node;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, kind, weight_row, node, value, input ready);
    modport sink   (input valid, kind, weight_row, node, value, output ready);
endinterface

interface dlmb_result_if import dlmb_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [NODE_W-1:0]          node_index;
    logic signed [VALUE_W-1:0]  out_value;
    logic                       last;

    modport source (output valid, node_index, out_value, last, input ready);
    modport sink   (input valid, node_index, out_value, last, output ready);
endinterface

FILE: hdl/dense_layer_mac_bias_top.sv
// Top level of the dense layer MAC/bias block (y = xW + b, 16-bit wrap).
// Depends on dlmb_pkg, dlmb_if (item/result channels) and dlmb_cell.
//
// Usage: weight loads, bias loads and features are taken one per cycle. Each
// request enters a chain of node cells and moves one cell per clock; cell n
// keeps weight column n in a local memory, bias n and accumulator n, so every
// node updates in parallel, each cell trailing the one before it. The feature
// that closes a row (input_count features) stops intake: the block then
// delivers node_count results in node order, last marked on the final one, and
// takes requests again after that result is accepted. The result of node n is
// ready once the closing feature has passed cell n's token register, weight and
// feature registers, product register and result register; with the receiver
// ready the results go out back to back. Loads of a missing row or node and
// kind 3 requests are dropped. Weights and biases are not cleared by reset and
// must be written before use. Configuration (input_count, node_count) must be
// written by the user while idle; the block itself does not enforce it.
module dense_layer_mac_bias_top
    import dlmb_pkg::*;
#(
    parameter int MAX_INPUTS = 64,
    parameter int MAX_NODES  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    dlmb_item_if.sink             item,
    dlmb_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // node field is 4 bits, so at most 16 cells
    localparam int NCELL  = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
    localparam int CIDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;

    // configuration
    logic [POS_W-1:0]     input_count_reg;
    logic [NCOUNT_W-1:0]  node_count_reg;
    logic [POS_W-1:0]     nin;
    logic [NCOUNT_W-1:0]  nn;

    // row control
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [POS_W-1:0]     pos_addr;
    logic                 busy_reg;
    logic [CIDX_W-1:0]    rd_idx_reg;
    logic [NCOUNT_W-1:0]  nn_out_reg;
    logic                 row_end;
    logic                 in_fire;
    logic                 out_fire;
    logic                 out_last;

    tok_t                 tok_new;
    tok_t                 chain [NCELL+1];
    logic [NCELL-1:0]     res_valid;
    logic [VALUE_W-1:0]   res_value [NCELL];
    logic [NCELL-1:0]     res_clr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg <= POS_W'(64);
            node_count_reg  <= NCOUNT_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_COUNT: input_count_reg <= cfg_data;
                REG_NODE_COUNT:  node_count_reg  <= cfg_data[NCOUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective counts: zero counts as one, larger values saturate to what the hardware holds
    always_comb
    begin
        nin = input_count_reg;
        if (nin == '0)
        begin
            nin = POS_W'(1);
        end
        else if (int'(input_count_reg) > MAX_INPUTS)
        begin
            nin = POS_W'(MAX_INPUTS);
        end
        nn = node_count_reg;
        if (nn == '0)
        begin
            nn = NCOUNT_W'(1);
        end
        else if (int'(node_count_reg) > NCELL)
        begin
            nn = NCOUNT_W'(NCELL);
        end
    end

    assign item.ready = !busy_reg;
    assign in_fire    = item.valid && item.ready;
    assign pos_next   = pos_reg + POS_W'(1);
    assign row_end    = (pos_next >= nin);
    // a position beyond MAX_INPUTS - 1 reads the top weight row
    assign pos_addr   = (int'(pos_reg) > MAX_INPUTS - 1) ? POS_W'(MAX_INPUTS - 1) : pos_reg;

    always_comb
    begin
        tok_new       = '0;
        tok_new.node  = item.node;
        tok_new.nn    = nn;
        tok_new.value = item.value;
        tok_new.addr  = {1'b0, item.weight_row};
        if (in_fire)
        begin
            case (item.kind)
                KIND_WEIGHT:
                begin
                    tok_new.wr_w = (int'(item.weight_row) < MAX_INPUTS)
                                && (int'(item.node) < MAX_NODES);
                end
                KIND_BIAS:
                begin
                    tok_new.wr_b = (int'(item.node) < MAX_NODES);
                end
                KIND_FEATURE:
                begin
                    tok_new.feat = 1'b1;
                    tok_new.last = row_end;
                    tok_new.addr = pos_addr;
                end
                default: ;
            endcase
        end
    end

    assign chain[0] = tok_new;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            dlmb_cell #(
                .MAX_INPUTS (MAX_INPUTS),
                .IDX        (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .tok_in    (chain[g]),
                .tok_out   (chain[g+1]),
                .res_clr   (res_clr[g]),
                .res_valid (res_valid[g]),
                .res_value (res_value[g])
            );
            assign res_clr[g] = out_fire && (rd_idx_reg == CIDX_W'(g));
        end
    endgenerate

    // results are read out in node order as each cell finishes
    assign out_last          = ({{(NCOUNT_W-CIDX_W){1'b0}}, rd_idx_reg} + NCOUNT_W'(1))
                               == nn_out_reg;
    assign result.valid      = busy_reg && res_valid[rd_idx_reg];
    assign result.node_index = NODE_W'(rd_idx_reg);
    assign result.out_value  = res_value[rd_idx_reg];
    assign result.last       = out_last;
    assign out_fire          = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            busy_reg   <= 1'b0;
            rd_idx_reg <= '0;
            nn_out_reg <= NCOUNT_W'(1);
        end
        else
        begin
            if (in_fire && (item.kind == KIND_FEATURE))
            begin
                if (row_end)
                begin
                    pos_reg    <= '0;
                    busy_reg   <= 1'b1;
                    rd_idx_reg <= '0;
                    nn_out_reg <= nn;
                end
                else
                begin
                    pos_reg <= pos_next;
                end
            end
            if (out_fire)
            begin
                if (out_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + CIDX_W'(1);
                end
            end
        end
    end

    a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> busy_reg)
        else $error("result offered outside readout");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({{(NCOUNT_W-CIDX_W){1'b0}}, rd_idx_reg} < nn_out_reg))
        else $error("readout index beyond node count");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && result.last) |=> (!busy_reg && item.ready))
        else $error("block still busy after last result");

    a_row_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (item.kind == KIND_FEATURE) && row_end) |=> (busy_reg && pos_reg == '0))
        else $error("row end did not start readout");

endmodule

FILE: hdl/dlmb_cell.sv
// One node cell: weight column memory, bias, accumulator and result register.
// Passes each request to its neighbor through its token register. Depends on dlmb_pkg.
module dlmb_cell
    import dlmb_pkg::*;
#(
    parameter int MAX_INPUTS = 64,
    parameter int IDX        = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tok_t                tok_in,
    output tok_t                tok_out,
    input  logic                res_clr,
    output logic                res_valid,
    output logic [VALUE_W-1:0]  res_value
);

    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    tok_t                tok_reg;
    logic [VALUE_W-1:0]  wmem [MAX_INPUTS];
    logic [VALUE_W-1:0]  wgt_reg;
    logic [VALUE_W-1:0]  bias_reg;
    logic [VALUE_W-1:0]  x2_reg;
    logic [VALUE_W-1:0]  prod_reg;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  acc_next;
    logic [VALUE_W-1:0]  res_value_reg;
    logic                res_valid_reg;
    logic                feat2_reg, last2_reg, en2_reg;
    logic                feat3_reg, last3_reg, en3_reg;
    logic                mine;
    logic                en;
    logic [AW-1:0]       addr;

    assign mine = (tok_reg.node == NODE_W'(IDX));
    assign en   = (int'(tok_reg.nn) > IDX);
    assign addr = AW'(tok_reg.addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    // weight column: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (tok_reg.wr_w && mine)
        begin
            wmem[addr] <= tok_reg.value;
        end
        wgt_reg <= wmem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (tok_reg.wr_b && mine)
        begin
            bias_reg <= tok_reg.value;
        end
        x2_reg   <= tok_reg.value;
        prod_reg <= VALUE_W'(x2_reg * wgt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feat2_reg <= 1'b0;
            last2_reg <= 1'b0;
            en2_reg   <= 1'b0;
            feat3_reg <= 1'b0;
            last3_reg <= 1'b0;
            en3_reg   <= 1'b0;
        end
        else
        begin
            feat2_reg <= tok_reg.feat;
            last2_reg <= tok_reg.last;
            en2_reg   <= en;
            feat3_reg <= feat2_reg;
            last3_reg <= last2_reg;
            en3_reg   <= en2_reg;
        end
    end

    assign acc_next = en3_reg ? (acc_reg + prod_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (feat3_reg)
            begin
                acc_reg <= last3_reg ? '0 : acc_next;
            end
            if (feat3_reg && last3_reg && en3_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_clr)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat3_reg && last3_reg)
        begin
            res_value_reg <= acc_next + bias_reg;
        end
    end

    assign tok_out   = tok_reg;
    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;

endmodule
